// ===== rtl/core/aifp_pkg.sv =====
// Shared types, constants and a helper function for the ASCII integer field parser.
package aifp_pkg;

	localparam int ACC_BITS   = 64;
	localparam int COUNT_BITS = 16;
	localparam int ADDR_BITS  = 4;

	// base_code register values
	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_HEX = 2'd1;
	localparam logic [1:0] BASE_OCT = 2'd2;
	localparam logic [1:0] BASE_BIN = 2'd3;

	// result_bits_code register values
	localparam logic [1:0] RB_8  = 2'd0;
	localparam logic [1:0] RB_16 = 2'd1;
	localparam logic [1:0] RB_32 = 2'd2;
	localparam logic [1:0] RB_64 = 2'd3;

	// register indexes on the configuration port
	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_RBITS  = 2'd2;
	localparam logic [1:0] REG_SIGNED = 2'd3;

	// status codes
	localparam logic [1:0] ST_MATCH   = 2'd0;
	localparam logic [1:0] ST_NO_DIG  = 2'd1;
	localparam logic [1:0] ST_EOF     = 2'd2;

	// characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_UB    = 8'h42;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

	// Decode one character as a digit of the selected base.
	function automatic digit_t digit_decode(input logic [7:0] b, input logic [1:0] base);
		digit_t d;
		logic [4:0] lim;
		d.ok  = 1'b0;
		d.val = 4'd0;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			d.ok  = 1'b1;
			d.val = 4'(b - CH_ZERO);
		end else if (b >= CH_LA && b <= CH_LF) begin
			d.ok  = 1'b1;
			d.val = 4'(b - CH_LA + 8'd10);
		end else if (b >= CH_UA && b <= CH_UF) begin
			d.ok  = 1'b1;
			d.val = 4'(b - CH_UA + 8'd10);
		end
		case (base)
			BASE_DEC: lim = 5'd10;
			BASE_HEX: lim = 5'd16;
			BASE_OCT: lim = 5'd8;
			BASE_BIN: lim = 5'd2;
			default:  lim = 5'd10;
		endcase
		if ({1'b0, d.val} >= lim)
			d.ok = 1'b0;
		return d;
	endfunction

endpackage

// ===== rtl/core/ascii_integer_field_parser_unit.sv =====
// Top level of the ASCII integer field parser: config registers, input stage, parse step, result register.
//
// Usage:
//   The input channel (in_valid / in_stall, payload in_byte and end_of_input) carries one
//   character of a text stream per transaction. The parser skips whitespace, takes a sign,
//   an optional 0x / 0b prefix in base 16 / 2, and digits, and produces one result
//   transaction on the output channel (out_valid / out_stall, payload value, status,
//   chars_used, stop_valid, stop_byte) on the character that ends the field: a non-digit
//   (handed back as stop_byte), end of input, or the field width limit.
//   Throughput is one character per cycle while no stalled result blocks the input stage,
//   set by the combinational parse step that reads and writes the field state (accumulator,
//   count, width left) for every character. A character accepted at one edge sits in the
//   input stage, and the parse step loads its result into the result register as the input
//   stage drains; out_valid comes from that result register.
//   When the receiver stalls a waiting result, the input stage still takes one character;
//   in_stall rises only while the input stage is occupied and the receiver stalls a waiting result.
//   Registers (base_code, max_field_width, result_bits_code, signed_result) read back at the same
//   addresses; the user writes them over the APB-style port only while the block is idle (not enforced).
//   Reset clears the field state to whitespace skipping, empties both stages and loads the
//   register defaults (decimal, unlimited width, 64-bit signed result).
module ascii_integer_field_parser_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	// input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 in_byte,
	input  logic                       end_of_input,
	// output channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [63:0]                value,
	output logic [1:0]                 status,
	output logic [15:0]                chars_used,
	output logic                       stop_valid,
	output logic [7:0]                 stop_byte,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [aifp_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import aifp_pkg::*;

	typedef enum logic [1:0] {
		PH_WS,
		PH_START,
		PH_ZERO,
		PH_DIGITS
	} phase_t;

	// configuration registers
	logic [1:0]  base_code_q;
	logic [15:0] max_width_q;
	logic [1:0]  rbits_q;
	logic        signed_q;

	// field state
	phase_t                phase_q;
	logic [ACC_BITS-1:0]   acc_q;
	logic                  neg_q;
	logic                  seen_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [15:0]           wleft_q;
	logic                  wlim_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	// result register
	logic        out_valid_q;
	logic [63:0] value_q;
	logic [1:0]  status_q;
	logic [15:0] used_q;
	logic        stopv_q;
	logic [7:0]  stopb_q;

	logic out_blocked;
	logic fire;
	logic cfg_wr;

	// next-state of the parse step
	phase_t                n_phase;
	logic [ACC_BITS-1:0]   n_acc;
	logic                  n_neg;
	logic                  n_seen;
	logic [COUNT_BITS-1:0] n_count;
	logic [15:0]           n_wleft;
	logic                  n_wlim;
	logic                  emit;
	logic [1:0]            e_status;
	logic                  e_stopv;
	logic [63:0]           e_value;

	function automatic logic [COUNT_BITS-1:0] cnt_add(input logic [COUNT_BITS-1:0] c,
			input logic [1:0] n);
		logic [COUNT_BITS:0] s;
		s = {1'b0, c} + (COUNT_BITS+1)'(n);
		return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
	endfunction

	function automatic logic [15:0] wtake(input logic [15:0] wl, input logic lim,
			input logic [1:0] n);
		logic [15:0] r;
		r = wl;
		if (lim)
			r = (wl >= 16'(n)) ? wl - 16'(n) : 16'd0;
		return r;
	endfunction

	//--------------------------------------------------------------------------------
	// Configuration port: zero wait states, write on the access phase.
	//--------------------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_code_q <= BASE_DEC;
			max_width_q <= 16'd0;
			rbits_q     <= RB_64;
			signed_q    <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_BASE:   base_code_q <= pwdata[1:0];
				REG_WIDTH:  max_width_q <= pwdata[15:0];
				REG_RBITS:  rbits_q     <= pwdata[1:0];
				REG_SIGNED: signed_q    <= pwdata[0];
				default:    base_code_q <= base_code_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_BASE:   prdata = {30'd0, base_code_q};
			REG_WIDTH:  prdata = {16'd0, max_width_q};
			REG_RBITS:  prdata = {30'd0, rbits_q};
			REG_SIGNED: prdata = {31'd0, signed_q};
			default:    prdata = 32'd0;
		endcase
	end

	//--------------------------------------------------------------------------------
	// Handshake: the input stage drains whenever the result register can take a result.
	//--------------------------------------------------------------------------------
	assign out_blocked = out_valid_q & out_stall;
	assign in_stall    = valid_s1 & out_blocked;
	assign fire        = valid_s1 & ~out_blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
			eof_s1  <= end_of_input;
		end
	end

	//--------------------------------------------------------------------------------
	// Parse step: one character against the field state.
	//--------------------------------------------------------------------------------
	always_comb begin
		logic                  go_digit;
		logic                  eligible;
		logic                  sigil;
		logic                  is_space;
		logic [ACC_BITS-1:0]   mul;
		logic [ACC_BITS-1:0]   signed_acc;
		logic [63:0]           v64;
		digit_t                dg;

		n_phase  = phase_q;
		n_acc    = acc_q;
		n_neg    = neg_q;
		n_seen   = seen_q;
		n_count  = count_q;
		n_wleft  = wleft_q;
		n_wlim   = wlim_q;
		emit     = 1'b0;
		e_status = ST_MATCH;
		e_stopv  = 1'b0;
		go_digit = 1'b0;
		eligible = 1'b0;
		sigil    = 1'b0;
		mul      = '0;
		is_space = (byte_s1 == CH_SPACE) || (byte_s1 >= CH_TAB && byte_s1 <= CH_CR);
		dg       = digit_decode(byte_s1, base_code_q);

		case (phase_q)
			PH_START: begin
				if (eof_s1) begin
					emit     = 1'b1;
					e_status = ST_EOF;
				end else begin
					eligible = (base_code_q == BASE_HEX || base_code_q == BASE_BIN) &&
						(!n_wlim || n_wleft >= 16'd3);
					if (eligible && byte_s1 == CH_ZERO)
						n_phase = PH_ZERO;
					else
						go_digit = 1'b1;
				end
			end
			PH_DIGITS: begin
				go_digit = 1'b1;
			end
			PH_ZERO: begin
				if (eof_s1) begin
					// lone zero before end of input: matched value 0
					n_acc    = '0;
					n_seen   = 1'b1;
					n_count  = cnt_add(n_count, 2'd1);
					emit     = 1'b1;
					e_status = ST_MATCH;
				end else begin
					sigil = (base_code_q == BASE_HEX && (byte_s1 == CH_LX || byte_s1 == CH_UX)) ||
						(base_code_q == BASE_BIN && (byte_s1 == CH_LB || byte_s1 == CH_UB));
					n_phase = PH_DIGITS;
					if (sigil) begin
						n_count = cnt_add(n_count, 2'd2);
						n_wleft = wtake(n_wleft, n_wlim, 2'd2);
					end else begin
						// the zero was a digit; this character goes to the digit path
						n_acc    = '0;
						n_seen   = 1'b1;
						n_count  = cnt_add(n_count, 2'd1);
						n_wleft  = wtake(n_wleft, n_wlim, 2'd1);
						go_digit = 1'b1;
					end
				end
			end
			default: begin
				if (eof_s1) begin
					emit     = 1'b1;
					e_status = ST_EOF;
				end else if (is_space) begin
					n_count = cnt_add(n_count, 2'd1);
				end else begin
					n_wlim  = (max_width_q != 16'd0);
					n_wleft = max_width_q;
					if (byte_s1 == CH_MINUS || byte_s1 == CH_PLUS) begin
						n_neg   = (byte_s1 == CH_MINUS);
						n_count = cnt_add(n_count, 2'd1);
						n_wleft = wtake(n_wleft, n_wlim, 2'd1);
						n_phase = PH_START;
						if (n_wlim && n_wleft == 16'd0) begin
							// sign used up the whole width
							emit     = 1'b1;
							e_status = ST_NO_DIG;
						end
					end else begin
						eligible = (base_code_q == BASE_HEX || base_code_q == BASE_BIN) &&
							(!n_wlim || n_wleft >= 16'd3);
						if (eligible && byte_s1 == CH_ZERO)
							n_phase = PH_ZERO;
						else
							go_digit = 1'b1;
					end
				end
			end
		endcase

		if (go_digit) begin
			n_phase = PH_DIGITS;
			if (eof_s1) begin
				emit     = 1'b1;
				e_status = n_seen ? ST_MATCH : ST_EOF;
			end else if (!dg.ok) begin
				emit     = 1'b1;
				e_status = n_seen ? ST_MATCH : ST_NO_DIG;
				e_stopv  = 1'b1;
			end else begin
				case (base_code_q)
					BASE_HEX: mul = n_acc << 4;
					BASE_OCT: mul = n_acc << 3;
					BASE_BIN: mul = n_acc << 1;
					default:  mul = (n_acc << 3) + (n_acc << 1);
				endcase
				n_acc   = mul + ACC_BITS'(dg.val);
				n_seen  = 1'b1;
				n_count = cnt_add(n_count, 2'd1);
				n_wleft = wtake(n_wleft, n_wlim, 2'd1);
				if (n_wlim && n_wleft == 16'd0) begin
					emit     = 1'b1;
					e_status = ST_MATCH;
				end
			end
		end

		// negate, truncate to the result width, then extend
		signed_acc = n_neg ? ACC_BITS'(0) - n_acc : n_acc;
		v64        = 64'(signed_acc);
		case (rbits_q)
			RB_8:    e_value = {{56{signed_q & v64[7]}}, v64[7:0]};
			RB_16:   e_value = {{48{signed_q & v64[15]}}, v64[15:0]};
			RB_32:   e_value = {{32{signed_q & v64[31]}}, v64[31:0]};
			default: e_value = v64;
		endcase
		if (e_status != ST_MATCH)
			e_value = 64'd0;
	end

	//--------------------------------------------------------------------------------
	// Field state: advance on every processed character, drop back to whitespace
	// skipping once a result is produced.
	//--------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WS;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
			count_q <= '0;
			wleft_q <= 16'd0;
			wlim_q  <= 1'b0;
		end else if (fire) begin
			if (emit) begin
				phase_q <= PH_WS;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				seen_q  <= 1'b0;
				count_q <= '0;
				wleft_q <= 16'd0;
				wlim_q  <= 1'b0;
			end else begin
				phase_q <= n_phase;
				acc_q   <= n_acc;
				neg_q   <= n_neg;
				seen_q  <= n_seen;
				count_q <= n_count;
				wleft_q <= n_wleft;
				wlim_q  <= n_wlim;
			end
		end
	end

	//--------------------------------------------------------------------------------
	// Result register: hold while stalled.
	//--------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			value_q  <= e_value;
			status_q <= e_status;
			used_q   <= (32'(n_count) > 32'h0000_FFFF) ? 16'hFFFF : 16'(n_count);
			stopv_q  <= e_stopv;
			stopb_q  <= e_stopv ? byte_s1 : 8'd0;
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign status     = status_q;
	assign chars_used = used_q;
	assign stop_valid = stopv_q;
	assign stop_byte  = stopb_q;

`ifndef SYNTHESIS
	// a failed field never carries a value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_MATCH |-> value == 64'd0)
		else $error("nonzero value on failed field");

	// end of input never hands back a stop byte
	a_eof_no_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EOF |-> !stop_valid)
		else $error("stop byte on end-of-input status");

	// a produced result leaves the field state cleared
	a_clear_after: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit |=> phase_q == PH_WS && count_q == '0 && !seen_q)
		else $error("field state not cleared after result");

	// a processed character never overwrites a result that is still stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> !(out_valid_q && out_stall))
		else $error("parse step fired into a stalled result register");
`endif

endmodule

// ===== verif/tb_ascii_integer_field_parser_unit.sv =====
// Self-checking testbench for the ASCII integer field parser: directed and random text streams.
module tb_ascii_integer_field_parser_unit;
	import aifp_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int CYCLE_LIMIT   = 200000;
	// two-stage pipeline; give a little more before touching registers
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_CHARS   = 35;

	localparam logic [1:0] BASE_ORDER [4] = '{BASE_DEC, BASE_HEX, BASE_OCT, BASE_BIN};
	localparam logic [1:0] RB_ORDER   [4] = '{RB_8, RB_16, RB_32, RB_64};

	// receiver stall patterns
	localparam int STALL_NONE   = 0;
	localparam int STALL_LIGHT  = 1;
	localparam int STALL_COMB   = 2;
	localparam int STALL_HEAVY  = 3;

	typedef enum logic [1:0] {
		PS_SKIP_WS,
		PS_AFTER_SIGN,
		PS_ZERO,
		PS_DIGITS
	} parse_phase_t;

	typedef struct {
		logic [7:0] ch;
		logic       eoi;
		bit         drain;	// hold this character until no result is outstanding
	} stream_char_t;

	typedef struct {
		logic [63:0] value;
		logic [1:0]  status;
		logic [15:0] chars_used;
		logic        stop_valid;
		logic [7:0]  stop_byte;
	} field_result_t;

	// clock, reset and block ports; every input starts at a known value
	logic        clk;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte      = 8'h00;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [63:0] value;
	logic [1:0]  status;
	logic [15:0] chars_used;
	logic        stop_valid;
	logic [7:0]  stop_byte;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata       = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	// stimulus and scoreboard
	stream_char_t  char_queue[$];
	field_result_t expected_fields[$];
	field_result_t oldest_field;
	stream_char_t  next_char;
	bit            in_taken     = 1'b0;
	bit            pending_drain = 1'b0;
	bit            sender_idles = 1'b1;
	int            stall_mode   = STALL_NONE;
	int            burst_left   = 0;
	int            gap_left     = 0;
	int            cycle_count  = 0;
	int            error_count  = 0;
	int            chars_queued = 0;
	int            fields_predicted = 0;
	int            results_checked  = 0;
	int            settings_applied = 0;

	// shadow of the configuration registers
	logic [1:0]  cfg_base   = BASE_DEC;
	logic [15:0] cfg_width  = 16'd0;
	logic [1:0]  cfg_rbits  = RB_64;
	logic        cfg_signed = 1'b1;

	// field state of the predictor
	parse_phase_t ps          = PS_SKIP_WS;
	logic [63:0]  acc         = 64'd0;
	logic         neg_sign    = 1'b0;
	logic         got_digit   = 1'b0;
	logic [15:0]  used_count  = 16'd0;
	logic [15:0]  width_left  = 16'd0;
	logic         width_on    = 1'b0;

	ascii_integer_field_parser_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value        (value),
		.status       (status),
		.chars_used   (chars_used),
		.stop_valid   (stop_valid),
		.stop_byte    (stop_byte),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Field predictor
	// ------------------------------------------------------------------

	function automatic int radix_of(logic [1:0] code);
		case (code)
			BASE_DEC: return 10;
			BASE_HEX: return 16;
			BASE_OCT: return 8;
			default:  return 2;
		endcase
	endfunction

	// Digit value of b in the given radix, or -1 when b is no digit of it.
	function automatic int digit_of(logic [7:0] b, int radix);
		int d;
		d = -1;
		if (b >= CH_ZERO && b <= CH_NINE)
			d = int'(b) - int'(CH_ZERO);
		else if (b >= CH_LA && b <= CH_LF)
			d = int'(b) - int'(CH_LA) + 10;
		else if (b >= CH_UA && b <= CH_UF)
			d = int'(b) - int'(CH_UA) + 10;
		return (d < radix) ? d : -1;
	endfunction

	// Saturate the consumed count at its 16-bit maximum.
	task automatic count_chars(int n);
		int c;
		c = int'(used_count) + n;
		used_count = (c > 65535) ? 16'hFFFF : 16'(c);
	endtask

	task automatic take_width(int n);
		if (width_on)
			width_left = (int'(width_left) >= n) ? width_left - 16'(n) : 16'd0;
	endtask

	// Emit the finished field into the expected store and start a new field.
	task automatic close_field(logic [1:0] st, logic sv, logic [7:0] sb);
		field_result_t r;
		logic [63:0] v;
		logic [63:0] m;
		int rb;
		v = 64'd0;
		if (st == ST_MATCH) begin
			v = neg_sign ? (64'd0 - acc) : acc;
			rb = 8 << cfg_rbits;
			if (rb < 64) begin
				m = (64'd1 << rb) - 64'd1;
				v = v & m;
				if (cfg_signed && v[rb-1])
					v = v | ~m;
			end
		end
		r.value      = v;
		r.status     = st;
		r.chars_used = used_count;
		r.stop_valid = sv;
		r.stop_byte  = sv ? sb : 8'h00;
		expected_fields.push_back(r);
		fields_predicted++;
		ps         = PS_SKIP_WS;
		acc        = 64'd0;
		neg_sign   = 1'b0;
		got_digit  = 1'b0;
		used_count = 16'd0;
		width_left = 16'd0;
		width_on   = 1'b0;
	endtask

	task automatic take_digit(logic [7:0] b, logic eoi);
		int d;
		int r;
		r = radix_of(cfg_base);
		if (eoi) begin
			close_field(got_digit ? ST_MATCH : ST_EOF, 1'b0, 8'h00);
		end else begin
			d = digit_of(b, r);
			if (d < 0) begin
				close_field(got_digit ? ST_MATCH : ST_NO_DIG, 1'b1, b);
			end else begin
				acc = acc * 64'(r) + 64'(d);
				got_digit = 1'b1;
				count_chars(1);
				take_width(1);
				if (width_on && width_left == 16'd0)
					close_field(ST_MATCH, 1'b0, 8'h00);
			end
		end
	endtask

	// First character after whitespace and sign: a zero may open a prefix.
	task automatic take_first(logic [7:0] b, logic eoi);
		int r;
		r = radix_of(cfg_base);
		if (eoi) begin
			close_field(ST_EOF, 1'b0, 8'h00);
		end else if ((r == 16 || r == 2) && (!width_on || width_left >= 16'd3) &&
				b == CH_ZERO) begin
			ps = PS_ZERO;
		end else begin
			ps = PS_DIGITS;
			take_digit(b, 1'b0);
		end
	endtask

	task automatic parse_char(logic [7:0] b, logic eoi);
		int r;
		r = radix_of(cfg_base);
		case (ps)
			PS_AFTER_SIGN: take_first(b, eoi);
			PS_DIGITS: take_digit(b, eoi);
			PS_ZERO: begin
				if (eoi) begin
					// a lone zero before end of input is a matched zero
					acc = 64'd0;
					got_digit = 1'b1;
					count_chars(1);
					close_field(ST_MATCH, 1'b0, 8'h00);
				end else if ((r == 16 && (b == CH_LX || b == CH_UX)) ||
						(r == 2 && (b == CH_LB || b == CH_UB))) begin
					count_chars(2);
					take_width(2);
					ps = PS_DIGITS;
				end else begin
					// the zero was a digit; this byte continues the number or stops it
					acc = 64'd0;
					got_digit = 1'b1;
					count_chars(1);
					take_width(1);
					ps = PS_DIGITS;
					take_digit(b, 1'b0);
				end
			end
			default: begin
				if (eoi) begin
					close_field(ST_EOF, 1'b0, 8'h00);
				end else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
					count_chars(1);
				end else begin
					// width limit latches at the first non-blank character
					width_on   = (cfg_width != 16'd0);
					width_left = cfg_width;
					if (b == CH_MINUS || b == CH_PLUS) begin
						neg_sign = (b == CH_MINUS);
						count_chars(1);
						take_width(1);
						if (width_on && width_left == 16'd0)
							close_field(ST_NO_DIG, 1'b0, 8'h00);
						else
							ps = PS_AFTER_SIGN;
					end else begin
						ps = PS_AFTER_SIGN;
						take_first(b, 1'b0);
					end
				end
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
		error_count++;
	endtask

	// Monitor: sample both handshakes at the rising edge. Check the result
	// first, then predict from the character taken on this same edge; the
	// block registers each character before its result comes out, so the order cannot matter.
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_fields.size() == 0) begin
				report_mismatch("result with none outstanding, value", value, 64'd0);
			end else begin
				oldest_field = expected_fields.pop_front();
				if (value !== oldest_field.value)
					report_mismatch("value", value, oldest_field.value);
				if (status !== oldest_field.status)
					report_mismatch("status", 64'(status), 64'(oldest_field.status));
				if (chars_used !== oldest_field.chars_used)
					report_mismatch("chars_used", 64'(chars_used),
						64'(oldest_field.chars_used));
				if (stop_valid !== oldest_field.stop_valid)
					report_mismatch("stop_valid", 64'(stop_valid),
						64'(oldest_field.stop_valid));
				if (stop_byte !== oldest_field.stop_byte)
					report_mismatch("stop_byte", 64'(stop_byte),
						64'(oldest_field.stop_byte));
				results_checked++;
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			parse_char(in_byte, end_of_input);
			in_taken = 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Driver and receiver, both at the falling edge
	// ------------------------------------------------------------------

	// Driver: hold a stalled transaction, else advance the queue in bursts of
	// random length separated by random gaps. A character marked for drain
	// waits until every outstanding result has arrived.
	always @(negedge clk) begin
		if (!arst_n) begin
			// stay idle through reset
		end else if (in_valid && !in_taken) begin
			// stalled: hold payload and valid
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left--;
		end else if (char_queue.size() != 0 &&
				!(char_queue[0].drain && expected_fields.size() != 0)) begin
			next_char = char_queue.pop_front();
			in_byte      <= next_char.ch;
			end_of_input <= next_char.eoi;
			in_valid     <= 1'b1;
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 12);
				gap_left   = sender_idles ? $urandom_range(0, 6) : 0;
			end else begin
				burst_left--;
			end
		end else begin
			in_valid <= 1'b0;
		end
		in_taken = 1'b0;
	end

	// Receiver: stall on a pattern chosen per phase.
	always @(negedge clk) begin
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
			STALL_COMB:  out_stall <= ((cycle_count % 7) < 3);
			default:     out_stall <= ($urandom_range(0, 99) < 75);
		endcase
	end

	// Watchdog on the cycle counter.
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("cycle limit reached with %0d results outstanding", expected_fields.size());
		$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic push_char(logic [7:0] c);
		char_queue.push_back('{c, 1'b0, pending_drain});
		pending_drain = 1'b0;
		chars_queued++;
	endtask

	// End of input: the byte lane carries random junk, which must be ignored.
	task automatic push_eoi();
		char_queue.push_back('{8'($urandom_range(0, 255)), 1'b1, pending_drain});
		pending_drain = 1'b0;
		chars_queued++;
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endtask

	function automatic logic [7:0] digit_char(int d);
		if (d < 10)
			return CH_ZERO + 8'(d);
		return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(d - 10);
	endfunction

	function automatic logic [7:0] blank_char();
		return ($urandom_range(0, 6) == 0) ? CH_SPACE : 8'($urandom_range(9, 13));
	endfunction

	// One random field: mostly well formed with random content, some noise
	// and some broken prefixes.
	task automatic gen_field();
		int r;
		int n;
		int k;
		r = radix_of(cfg_base);
		if ($urandom_range(0, 99) < 12) begin
			push_char(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++)
				push_char(blank_char());
			case ($urandom_range(0, 2))
				1: push_char(CH_PLUS);
				2: push_char(CH_MINUS);
				default: ;
			endcase
			if ((r == 16 || r == 2) && $urandom_range(0, 2) == 0) begin
				push_char(CH_ZERO);
				if ($urandom_range(0, 7) == 0)
					push_char(8'($urandom_range(0, 255)));
				else if (r == 16)
					push_char($urandom_range(0, 1) ? CH_LX : CH_UX);
				else
					push_char($urandom_range(0, 1) ? CH_LB : CH_UB);
			end
			// long runs can wrap the 64-bit accumulator
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 6);
			for (int i = 0; i < n; i++)
				push_char(digit_char($urandom_range(0, r - 1)));
			k = $urandom_range(0, 99);
			if (k < 35)
				push_char(blank_char());
			else if (k < 65)
				push_char(8'($urandom_range(0, 255)));
			else if (k < 78)
				push_eoi();
		end
	endtask

	// Wait until nothing is queued or outstanding, then let the pipeline drain.
	task automatic settle();
		while (char_queue.size() != 0 || in_valid || expected_fields.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup cycle then access cycle; the write lands on the edge with pready high.
	task automatic apb_write(logic [1:0] idx, logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apply_config(logic [1:0] base, logic [15:0] width, logic [1:0] rbits,
			logic sgn);
		settle();
		apb_write(REG_BASE, 32'(base));
		apb_write(REG_WIDTH, 32'(width));
		apb_write(REG_RBITS, 32'(rbits));
		apb_write(REG_SIGNED, 32'(sgn));
		cfg_base   = base;
		cfg_width  = width;
		cfg_rbits  = rbits;
		cfg_signed = sgn;
		settings_applied++;
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		int start;
		int w;
		bit paused;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Decimal, unlimited, 64-bit signed: blank, sign, digits, stop byte;
		// NUL forms a field with no digits; sign then end of input; end of input alone.
		stall_mode = STALL_LIGHT;
		apply_config(BASE_DEC, 16'd0, RB_64, 1'b1);
		push_text(" -12;");
		push_char(8'h00);
		push_char(CH_PLUS);
		push_eoi();
		push_eoi();

		// Hex into 8 signed bits: 0xff reads as all ones; lone zero at end of
		// input; prefix then end of input; prefix then non-digit; zero
		// followed by a non-prefix letter.
		apply_config(BASE_HEX, 16'd0, RB_8, 1'b1);
		push_text("0xff ");
		push_char(CH_ZERO);
		push_eoi();
		push_text("0x");
		push_eoi();
		push_text("0xz");
		push_text("0g");

		// Binary, width 1: the sign alone fills the width, a digit reaches it,
		// and a zero is too short to open a prefix.
		apply_config(BASE_BIN, 16'd1, RB_16, 1'b0);
		push_text("+1 0");

		// Hex, width 3: the prefix just fits and the digit reaches the width.
		apply_config(BASE_HEX, 16'd3, RB_32, 1'b0);
		push_text("0X5");
		push_eoi();

		// Random phases over bases, widths, result sizes and sign modes.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			apply_config(BASE_ORDER[p % 4],
				(p == 3) ? 16'hFFFF : ((p % 3 == 0) ? 16'd0 : 16'($urandom_range(1, 12))),
				RB_ORDER[(p + p / 4) % 4], p[0]);
			stall_mode   = p % 4;
			sender_idles = (p % 5 != 1);
			start  = chars_queued;
			paused = 1'b0;
			while (chars_queued - start < PHASE_CHARS) begin
				// hold the sender mid-phase until all results are in
				if (!paused && p % 4 == 2 && chars_queued - start >= 18) begin
					pending_drain = 1'b1;
					paused = 1'b1;
				end
				gen_field();
			end
			// a long field may have ended the phase early; hold the sender here then
			if (!paused && p % 4 == 2)
				pending_drain = 1'b1;
			// close the phase so the field state is clear before reprogramming
			push_eoi();
		end

		while (char_queue.size() != 0 || in_valid)
			@(posedge clk);
		for (w = 0; w < 2000 && expected_fields.size() != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_fields.size() != 0)
			report_mismatch("results never delivered", 64'(expected_fields.size()), 64'd0);

		$display("sent %0d characters under %0d register settings, %0d fields predicted",
			chars_queued, settings_applied, fields_predicted);
		$display("checked %0d results, %0d mismatches", results_checked, error_count);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/aifp_pkg.sv
rtl/core/ascii_integer_field_parser_unit.sv
verif/tb_ascii_integer_field_parser_unit.sv
